### design/ssp_pkg.sv
package ssp_pkg;

  localparam int INDEX_BITS = 16;
  localparam int ROOT_BITS  = (INDEX_BITS + 2) / 2;
  localparam int RAD_BITS   = 2 * ROOT_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int R_BITS     = ROOT_BITS - 1;
  localparam int CALC_BITS  = INDEX_BITS + 2;
  localparam int OUT_BITS   = 9;

  typedef struct packed {
    logic                  vld;
    logic [INDEX_BITS-1:0] idx;
    logic [RAD_BITS-1:0]   rad;
    logic [REM_BITS-1:0]   rem;
    logic [ROOT_BITS-1:0]  root;
  } ssp_stage_t;

endpackage

### design/ssp_sqrt_cell.sv
module ssp_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ssp_pkg::ssp_stage_t stg_i,
  output ssp_pkg::ssp_stage_t stg_o
);
  import ssp_pkg::*;

  ssp_stage_t              stg_r;
  ssp_stage_t              stg_nxt;
  logic [REM_BITS+1:0]     rem_sh;
  logic [REM_BITS+1:0]     trial;
  logic                    ge;

  always_comb begin
    rem_sh  = {stg_i.rem, stg_i.rad[RAD_BITS-1 -: 2]};
    trial   = (REM_BITS+2)'({stg_i.root, 2'b01});
    ge      = (rem_sh >= trial);
    stg_nxt = stg_i;
    stg_nxt.rem  = ge ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
    stg_nxt.root = {stg_i.root[ROOT_BITS-2:0], ge};
    stg_nxt.rad  = stg_i.rad << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_o = stg_r;

endmodule

### design/ssp_map.sv
module ssp_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssp_pkg::ssp_stage_t            stg_i,
  output logic                          out_vld,
  output logic signed [ssp_pkg::OUT_BITS-1:0] out_x,
  output logic signed [ssp_pkg::OUT_BITS-1:0] out_y
);
  import ssp_pkg::*;

  logic [ROOT_BITS-1:0]    sm1;
  logic [R_BITS-1:0]       r_a;

  logic                    v1_r, z1_r;
  logic [INDEX_BITS-1:0]   idx1_r;
  logic [R_BITS-1:0]       r1_r;
  logic [2*R_BITS-1:0]     rsq1_r;

  logic [2*R_BITS:0]       qsum;
  logic [INDEX_BITS-1:0]   n_nxt;
  logic                    v2_r, z2_r;
  logic [INDEX_BITS-1:0]   n2_r;
  logic [R_BITS-1:0]       r2_r;

  logic signed [CALC_BITS-1:0] rs, ns, ring, xs, ys;
  logic                    v3_r;
  logic signed [OUT_BITS-1:0] x3_r, y3_r;

  assign sm1 = stg_i.root - ROOT_BITS'(1);
  assign r_a = sm1[ROOT_BITS-1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= stg_i.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    z1_r   <= (stg_i.idx == '0);
    idx1_r <= stg_i.idx;
    r1_r   <= r_a;
    rsq1_r <= r_a * r_a;
  end

  assign qsum  = (2*R_BITS+1)'(rsq1_r) + (2*R_BITS+1)'(r1_r);
  assign n_nxt = idx1_r - INDEX_BITS'({qsum, 2'b00});

  always_ff @(posedge clk) begin
    z2_r <= z1_r;
    n2_r <= n_nxt;
    r2_r <= r1_r;
  end

  always_comb begin
    rs   = signed'(CALC_BITS'(r2_r));
    ns   = signed'(CALC_BITS'(n2_r));
    ring = rs + CALC_BITS'(1);
    xs   = '0;
    ys   = '0;
    if (z2_r) begin
      xs = '0;
      ys = '0;
    end else if (ns == '0) begin
      xs = rs;
      ys = -CALC_BITS'(1);
    end else if (ns < rs + CALC_BITS'(2)) begin
      xs = ring;
      ys = ns - CALC_BITS'(1);
    end else if (ns < CALC_BITS'(3) * rs + CALC_BITS'(4)) begin
      xs = CALC_BITS'(2) * rs + CALC_BITS'(3) - ns;
      ys = ring;
    end else if (ns < CALC_BITS'(5) * rs + CALC_BITS'(6)) begin
      xs = -ring;
      ys = CALC_BITS'(4) * rs + CALC_BITS'(5) - ns;
    end else if (ns < CALC_BITS'(7) * rs + CALC_BITS'(8)) begin
      xs = ns - (CALC_BITS'(6) * rs + CALC_BITS'(7));
      ys = -ring;
    end else if (ns < CALC_BITS'(8) * rs + CALC_BITS'(8)) begin
      xs = ring;
      ys = ns - (CALC_BITS'(8) * rs + CALC_BITS'(9));
    end
  end

  always_ff @(posedge clk) begin
    x3_r <= OUT_BITS'(xs);
    y3_r <= OUT_BITS'(ys);
  end

  assign out_vld = v3_r;
  assign out_x   = x3_r;
  assign out_y   = y3_r;

endmodule

### design/square_spiral_index_to_xy_core.sv
// Throughput: one request per cycle; busy is always low.
// The pipeline is a row of ROOT_BITS square-root cells, one root bit per cell,
// followed by three mapping stages (multiply, ring offset, side select).
// Reset: synchronous active-low rst_n clears all valid flags; no results after reset.
// The receiver cannot stall: each result is shown for one cycle with out_valid.
module square_spiral_index_to_xy_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ssp_pkg::INDEX_BITS-1:0]       in_spiral_index,
  output logic                                 out_valid,
  output logic signed [ssp_pkg::OUT_BITS-1:0]  out_offset_x,
  output logic signed [ssp_pkg::OUT_BITS-1:0]  out_offset_y
);
  import ssp_pkg::*;

  ssp_stage_t head;
  ssp_stage_t chain [ROOT_BITS+1];

  assign busy = 1'b0;

  always_comb begin
    head.vld  = start & ~busy;
    head.idx  = in_spiral_index;
    head.rad  = RAD_BITS'({1'b0, in_spiral_index} + (INDEX_BITS+1)'(1));
    head.rem  = '0;
    head.root = '0;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    ssp_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .stg_i (chain[i]),
      .stg_o (chain[i+1])
    );
  end

  ssp_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .stg_i   (chain[ROOT_BITS]),
    .out_vld (out_valid),
    .out_x   (out_offset_x),
    .out_y   (out_offset_y)
  );

endmodule

### dv/tb.sv
module tb;

  localparam int IDX_W     = ssp_pkg::INDEX_BITS;
  localparam int XY_W      = ssp_pkg::OUT_BITS;
  localparam int LATENCY   = ssp_pkg::ROOT_BITS + 3;
  localparam int PHASE_LEN = 450;
  localparam int MAX_CYCLES = 200000;

  typedef struct {
    logic [IDX_W-1:0]       idx;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } spiral_xy_t;

  class spiral_scoreboard;
    spiral_xy_t expected_xy[$];
    int         errors;

    function int int_sqrt(input int v);
      int root;
      int trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function spiral_xy_t map_index_to_xy(input logic [IDX_W-1:0] idx);
      spiral_xy_t e;
      int s, r, n, ring, x, y;
      x = 0;
      y = 0;
      if (idx != 0) begin
        s    = int_sqrt(int'(idx) + 1);
        r    = (s - 1) / 2;
        n    = int'(idx) - 4 * (r * r + r);
        ring = r + 1;
        if (n == 0) begin
          x = r;
          y = -1;
        end else if (n < r + 2) begin
          x = ring;
          y = n - 1;
        end else if (n < 3 * r + 4) begin
          x = 2 * r + 3 - n;
          y = ring;
        end else if (n < 5 * r + 6) begin
          x = -ring;
          y = 4 * r + 5 - n;
        end else if (n < 7 * r + 8) begin
          x = n - (6 * r + 7);
          y = -ring;
        end else if (n < 8 * r + 8) begin
          x = ring;
          y = n - (8 * r + 9);
        end
      end
      e.idx = idx;
      e.x   = x[XY_W-1:0];
      e.y   = y[XY_W-1:0];
      return e;
    endfunction

    function void note_request(input logic [IDX_W-1:0] idx);
      expected_xy.push_back(map_index_to_xy(idx));
    endfunction

    function void check_result(input logic signed [XY_W-1:0] x,
                               input logic signed [XY_W-1:0] y);
      spiral_xy_t e;
      if (expected_xy.size() == 0) begin
        $error("result (%0d,%0d) with no request pending", x, y);
        errors++;
        return;
      end
      e = expected_xy.pop_front();
      if (x !== e.x) begin
        $error("offset_x for index %0d: expected %0d, actual %0d", e.idx, e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("offset_y for index %0d: expected %0d, actual %0d", e.idx, e.y, y);
        errors++;
      end
    endfunction

    function int pending();
      return expected_xy.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic [IDX_W-1:0]       in_spiral_index = '0;
  logic                   busy;
  logic                   out_valid;
  logic signed [XY_W-1:0] out_offset_x;
  logic signed [XY_W-1:0] out_offset_y;

  spiral_scoreboard sb = new();
  int               cycle_count = 0;

  square_spiral_index_to_xy_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_spiral_index (in_spiral_index),
    .out_valid       (out_valid),
    .out_offset_x    (out_offset_x),
    .out_offset_y    (out_offset_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_offset_x, out_offset_y);
  end

  task automatic send_index(input logic [IDX_W-1:0] idx, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_spiral_index <= idx;
    do @(negedge clk); while (busy !== 1'b0);
    sb.note_request(idx);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int r, k, v;
    case ($urandom_range(9))
      0, 1:    return IDX_W'($urandom_range(255));
      2, 3, 4: begin
        r = $urandom_range(127);
        case ($urandom_range(11))
          0:  k = 0;
          1:  k = 1;
          2:  k = r + 1;
          3:  k = r + 2;
          4:  k = 3 * r + 3;
          5:  k = 3 * r + 4;
          6:  k = 5 * r + 5;
          7:  k = 5 * r + 6;
          8:  k = 7 * r + 7;
          9:  k = 7 * r + 8;
          10: k = 8 * r + 7;
          default: k = 8 * r + 8;
        endcase
        v = 4 * (r * r + r) + k;
        if (v > 65535) v = 65535;
        return IDX_W'(v);
      end
      default: return IDX_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [IDX_W-1:0] corner_idx[$];
    int               idle_pct[3];
    corner_idx = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 14, 16, 18, 20, 22, 23, 24,
                   16'hFFFF, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};
    idle_pct = '{36, 63, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_idx[i]) send_index(corner_idx[i], 0);
    start <= 1'b0;
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < PHASE_LEN; i++) send_index(pick_index(), idle_pct[p]);
      start <= 1'b0;
      wait_drained();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
